FILE: hw/rtl/imufd_pkg.sv
// ----------------------------------------------------------------------------
// imufd_pkg: shared types and constants of the IMU serial frame decoder
// Frame layout, scaling constants, frame kinds and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imufd_pkg;

   // Frame layout: header, type, eight data bytes, checksum
   localparam int FRAME_BYTES  = 11;
   localparam int STORE_DEPTH  = FRAME_BYTES - 2;   // type and data, no checksum
   localparam int COUNT_W      = 4;
   localparam int STORE_IDX_W  = 4;
   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(FRAME_BYTES - 1);
   localparam logic [7:0] HEADER_BYTE = 8'h55;

   // Field widths
   localparam int WORD_W  = 16;
   localparam int VALUE_W = 20;
   localparam int KIND_W  = 3;

   // Scaling: value = trunc(|w| * factor / 2^SCALE_SHIFT), sign restored.
   // Each factor is rounded up so the truncation is exact for |w| <= 32768.
   localparam int SCALE_SHIFT = 21;
   localparam int FACTOR_W    = 25;
   localparam int PRODUCT_W   = WORD_W + FACTOR_W;
   localparam logic [FACTOR_W-1:0] FACTOR_ACCEL = 25'd2569012;   // 49/40
   localparam logic [FACTOR_W-1:0] FACTOR_TEMP  = 25'd5368710;   // 64/25
   localparam logic [FACTOR_W-1:0] FACTOR_GYRO  = 25'd32768000;  // 125/8
   localparam logic [FACTOR_W-1:0] FACTOR_EULER = 25'd2949120;   // 45/32
   localparam logic [FACTOR_W-1:0] FACTOR_UNIT  = 25'd2097152;   // 1
   localparam logic [FACTOR_W-1:0] FACTOR_ZERO  = 25'd0;

   // Gravity in 1/256 m/s^2
   localparam logic signed [VALUE_W-1:0] GRAVITY_Q8 = 20'sd2509;

   // Frame kinds
   localparam logic [KIND_W-1:0] KIND_ACCEL  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GYRO   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MAGNET = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EULER  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUAT   = 3'd4;

   // Register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_CODE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_CODE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGNET_CODE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EULER_CODE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUAT_CODE   = 3'd4;

   // Register reset values
   localparam logic [7:0] RESET_ACCEL_CODE  = 8'd81;
   localparam logic [7:0] RESET_GYRO_CODE   = 8'd82;
   localparam logic [7:0] RESET_MAGNET_CODE = 8'd84;
   localparam logic [7:0] RESET_EULER_CODE  = 8'd83;
   localparam logic [7:0] RESET_QUAT_CODE   = 8'd89;

   // Type byte codes from the register file
   typedef struct packed {
      logic [7:0] accel;
      logic [7:0] gyro;
      logic [7:0] magnet;
      logic [7:0] euler;
      logic [7:0] quat;
   } codes_type;

   // Gathered frame: type byte and four little-endian words
   typedef struct packed {
      logic [7:0]               type_code;
      logic [3:0][WORD_W-1:0]   words;
   } frame_type;

endpackage

FILE: hw/rtl/imufd_collect.sv
// ----------------------------------------------------------------------------
// imufd_collect: header hunt and frame byte gathering
// Counts frame bytes, keeps type and data bytes, flags the closing byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imufd_collect (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_rx_byte,
   input  logic                 out_block,
   output logic                 req_stall,
   output logic                 frame_done,
   output imufd_pkg::frame_type frame
);
   import imufd_pkg::*;

   logic [COUNT_W-1:0] byte_count_ff;
   logic [COUNT_W-1:0] byte_count_in;
   logic [7:0]         store_ff [0:STORE_DEPTH-1];
   logic [STORE_IDX_W-1:0] store_idx;
   logic               accept;
   logic               at_last;
   logic               store_wr;

   // Hold the closing byte only while the result register is blocked
   assign at_last    = (byte_count_ff == LAST_COUNT);
   assign req_stall  = at_last && out_block;
   assign accept     = req_valid && !req_stall;
   assign frame_done = accept && at_last;

   assign store_idx = STORE_IDX_W'(byte_count_ff - COUNT_W'(1));
   assign store_wr  = accept && (byte_count_ff != '0) && !at_last;

   // Advance the byte counter
   always_comb begin
      byte_count_in = byte_count_ff;
      if (accept) begin
         if (byte_count_ff == '0) begin
            if (req_rx_byte == HEADER_BYTE) begin
               byte_count_in = COUNT_W'(1);
            end
         end else if (at_last || (byte_count_ff > LAST_COUNT)) begin
            byte_count_in = '0;
         end else begin
            byte_count_in = byte_count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

   // Keep type and data bytes; the checksum is dropped
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[store_idx] <= req_rx_byte;
      end
   end

   // Present the gathered frame
   always_comb begin
      frame.type_code = store_ff[0];
      for (int k = 0; k < 4; k++) begin
         frame.words[k] = {store_ff[2 + 2 * k], store_ff[1 + 2 * k]};
      end
   end

endmodule

FILE: hw/rtl/imufd_lane.sv
// ----------------------------------------------------------------------------
// imufd_lane: one word scaler
// Multiplies the magnitude by a fixed-point factor, truncates, restores sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imufd_lane (
   input  logic [imufd_pkg::WORD_W-1:0]          word,
   input  logic [imufd_pkg::FACTOR_W-1:0]        factor,
   output logic signed [imufd_pkg::VALUE_W-1:0]  value
);
   import imufd_pkg::*;

   logic                 negative;
   logic [WORD_W-1:0]    magnitude;
   logic [PRODUCT_W-1:0] product;
   logic [VALUE_W-1:0]   quotient;

   // Truncate toward zero by scaling the magnitude
   assign negative  = word[WORD_W-1];
   assign magnitude = negative ? (~word + WORD_W'(1)) : word;
   assign product   = PRODUCT_W'(magnitude) * PRODUCT_W'(factor);
   assign quotient  = product[SCALE_SHIFT +: VALUE_W];
   assign value     = negative ? -$signed(quotient) : $signed(quotient);

endmodule

FILE: hw/rtl/imufd_decode.sv
// ----------------------------------------------------------------------------
// imufd_decode: frame kind selection, scaling and result register
// Matches the type byte, scales four words and holds the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imufd_decode (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  frame_done,
   input  imufd_pkg::frame_type                  frame,
   input  imufd_pkg::codes_type                  codes,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [imufd_pkg::KIND_W-1:0]          rsp_frame_kind,
   output logic signed [imufd_pkg::VALUE_W-1:0]  rsp_value_a,
   output logic signed [imufd_pkg::VALUE_W-1:0]  rsp_value_b,
   output logic signed [imufd_pkg::VALUE_W-1:0]  rsp_value_c,
   output logic signed [imufd_pkg::VALUE_W-1:0]  rsp_value_d
);
   import imufd_pkg::*;

   logic                      known;
   logic [KIND_W-1:0]         kind;
   logic [FACTOR_W-1:0]       factor_abc;
   logic [FACTOR_W-1:0]       factor_d;
   logic signed [VALUE_W-1:0] lane_a;
   logic signed [VALUE_W-1:0] lane_b;
   logic signed [VALUE_W-1:0] lane_c;
   logic signed [VALUE_W-1:0] lane_d;
   logic signed [VALUE_W-1:0] value_c;
   logic                      load;

   logic                      valid_ff;
   logic                      valid_in;
   logic [KIND_W-1:0]         kind_ff;
   logic signed [VALUE_W-1:0] value_a_ff;
   logic signed [VALUE_W-1:0] value_b_ff;
   logic signed [VALUE_W-1:0] value_c_ff;
   logic signed [VALUE_W-1:0] value_d_ff;

   // Match the type byte, first register wins
   always_comb begin
      known      = 1'b1;
      kind       = KIND_ACCEL;
      factor_abc = FACTOR_ACCEL;
      factor_d   = FACTOR_TEMP;
      if (frame.type_code == codes.accel) begin
         kind       = KIND_ACCEL;
      end else if (frame.type_code == codes.gyro) begin
         kind       = KIND_GYRO;
         factor_abc = FACTOR_GYRO;
         factor_d   = FACTOR_ZERO;
      end else if (frame.type_code == codes.magnet) begin
         kind       = KIND_MAGNET;
         factor_abc = FACTOR_UNIT;
         factor_d   = FACTOR_ZERO;
      end else if (frame.type_code == codes.euler) begin
         kind       = KIND_EULER;
         factor_abc = FACTOR_EULER;
         factor_d   = FACTOR_ZERO;
      end else if (frame.type_code == codes.quat) begin
         kind       = KIND_QUAT;
         factor_abc = FACTOR_UNIT;
         factor_d   = FACTOR_UNIT;
      end else begin
         known      = 1'b0;
      end
   end

   imufd_lane u_lane_a (.word(frame.words[0]), .factor(factor_abc), .value(lane_a));
   imufd_lane u_lane_b (.word(frame.words[1]), .factor(factor_abc), .value(lane_b));
   imufd_lane u_lane_c (.word(frame.words[2]), .factor(factor_abc), .value(lane_c));
   imufd_lane u_lane_d (.word(frame.words[3]), .factor(factor_d),   .value(lane_d));

   // Remove gravity from the accel Z axis
   assign value_c = (kind == KIND_ACCEL) ? (lane_c - GRAVITY_Q8) : lane_c;

   // Load on a known frame, drop the item once taken
   assign load = frame_done && known;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind;
         value_a_ff <= lane_a;
         value_b_ff <= lane_b;
         value_c_ff <= value_c;
         value_d_ff <= lane_d;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_kind = kind_ff;
   assign rsp_value_a    = value_a_ff;
   assign rsp_value_b    = value_b_ff;
   assign rsp_value_c    = value_c_ff;
   assign rsp_value_d    = value_d_ff;

endmodule

FILE: hw/rtl/imu_serial_frame_decoder.sv
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder: 11-byte IMU serial frame decoder
// Gathers header-framed bytes and emits one scaled sensor reading per frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one received byte per item. Bytes are dropped until a 0x55
//   header; the next ten bytes (type, eight data bytes, checksum) form a frame.
//   rsp_* gives one item per frame whose type byte matches a code register:
//   frame kind and four signed 20-bit values. Unknown types give no item.
//   csr_* writes the five type codes; write them only while the block is idle.
// Throughput and result timing:
//   One byte is taken every cycle unless req_stall holds the closing byte. The
//   result item appears in the cycle after the checksum byte is taken, from the single result register.
// Reset:
//   Synchronous; the byte counter returns to header hunt, the result register
//   empties and the type codes return to 81, 82, 84, 83 and 89.
// Stall:
//   While a result waits under rsp_stall, bytes keep flowing; only the closing
//   byte of the next frame is held with req_stall until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_serial_frame_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [imufd_pkg::KIND_W-1:0]          rsp_frame_kind,
   output logic signed [imufd_pkg::VALUE_W-1:0]  rsp_value_a,
   output logic signed [imufd_pkg::VALUE_W-1:0]  rsp_value_b,
   output logic signed [imufd_pkg::VALUE_W-1:0]  rsp_value_c,
   output logic signed [imufd_pkg::VALUE_W-1:0]  rsp_value_d,
   input  logic                                  csr_wr_en,
   input  logic [imufd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                            csr_wr_data
);
   import imufd_pkg::*;

   codes_type codes_ff;
   codes_type codes_in;
   frame_type frame;
   logic      frame_done;
   logic      out_block;

   // Write the type code registers
   always_comb begin
      codes_in = codes_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACCEL_CODE:  codes_in.accel  = csr_wr_data;
            CSR_GYRO_CODE:   codes_in.gyro   = csr_wr_data;
            CSR_MAGNET_CODE: codes_in.magnet = csr_wr_data;
            CSR_EULER_CODE:  codes_in.euler  = csr_wr_data;
            CSR_QUAT_CODE:   codes_in.quat   = csr_wr_data;
            default:         codes_in = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.accel  <= RESET_ACCEL_CODE;
         codes_ff.gyro   <= RESET_GYRO_CODE;
         codes_ff.magnet <= RESET_MAGNET_CODE;
         codes_ff.euler  <= RESET_EULER_CODE;
         codes_ff.quat   <= RESET_QUAT_CODE;
      end else begin
         codes_ff <= codes_in;
      end
   end

   // The result register is blocked while its item waits
   assign out_block = rsp_valid && rsp_stall;

   imufd_collect u_collect (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .out_block   (out_block),
      .req_stall   (req_stall),
      .frame_done  (frame_done),
      .frame       (frame)
   );

   imufd_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .frame_done     (frame_done),
      .frame          (frame),
      .codes          (codes_ff),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_value_a    (rsp_value_a),
      .rsp_value_b    (rsp_value_b),
      .rsp_value_c    (rsp_value_c),
      .rsp_value_d    (rsp_value_d)
   );

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the IMU serial frame decoder
// Streams header-framed byte sequences through the decoder under random
// request gaps and result stalls, predicts every sensor reading from the
// bytes actually taken and compares each reading field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import imufd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int BODY_BYTES = FRAME_BYTES - 1;
   localparam int IDLE_PCT = 26;
   localparam int DIRECTED_ROWS = 10;

   // One decoded reading as it leaves the rsp channel
   typedef struct {
      logic [KIND_W-1:0]         frame_kind;
      logic signed [VALUE_W-1:0] value_a;
      logic signed [VALUE_W-1:0] value_b;
      logic signed [VALUE_W-1:0] value_c;
      logic signed [VALUE_W-1:0] value_d;
   } sensor_reading_type;

   // One directed frame: optional idle byte ahead, frame body, typed reading
   typedef struct {
      logic [7:0]         lead;
      bit                 has_lead;
      logic [7:0]         type_code;
      logic [0:3][15:0]   words;
      logic [7:0]         csum;
      bit                 typed;
      sensor_reading_type want;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_frame_kind;
   logic signed [VALUE_W-1:0] rsp_value_a;
   logic signed [VALUE_W-1:0] rsp_value_b;
   logic signed [VALUE_W-1:0] rsp_value_c;
   logic signed [VALUE_W-1:0] rsp_value_d;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ACCEL_CODE;
   logic [7:0] csr_wr_data = 8'h00;

   // Decoder shadow state
   codes_type code_regs;
   int frame_pos;
   logic [7:0] frame_body [BODY_BYTES];

   sensor_reading_type pending_readings [$];
   sensor_reading_type typed_reading;
   bit typed_row;
   bit calm;
   int fail_count = 0;
   int readings_checked = 0;
   int bytes_taken;
   int bytes_dropped;
   int code_settings;
   int cycle_count = 0;

   frame_row_type directed_frames [DIRECTED_ROWS] = '{
      '{8'hFF, 1'b1, RESET_ACCEL_CODE, {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 8'h00,
        1'b1, '{KIND_ACCEL, 20'sd0, 20'sd0, -20'sd2509, 20'sd0}},
      '{8'h00, 1'b0, RESET_ACCEL_CODE, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 8'hA5,
        1'b1, '{KIND_ACCEL, 20'sd40139, -20'sd40140, 20'sd37630, -20'sd83886}},
      '{8'h00, 1'b0, RESET_ACCEL_CODE, {16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF}, 8'h3C,
        1'b1, '{KIND_ACCEL, -20'sd1, 20'sd1, -20'sd2510, -20'sd2}},
      '{8'h00, 1'b0, RESET_GYRO_CODE, {16'h7FFF, 16'h8000, 16'h0000, 16'h1234}, 8'h00,
        1'b1, '{KIND_GYRO, 20'sd511984, -20'sd512000, 20'sd0, 20'sd0}},
      '{8'h00, 1'b0, RESET_MAGNET_CODE, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0005}, 8'h11,
        1'b1, '{KIND_MAGNET, -20'sd32768, 20'sd32767, -20'sd1, 20'sd0}},
      '{8'h00, 1'b0, RESET_EULER_CODE, {16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, 8'h22,
        1'b1, '{KIND_EULER, 20'sd46078, -20'sd46080, -20'sd1, 20'sd0}},
      '{8'h00, 1'b0, RESET_QUAT_CODE, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF}, 8'h33,
        1'b1, '{KIND_QUAT, 20'sd32767, -20'sd32768, 20'sd1, -20'sd1}},
      // unknown type with header values as data and checksum: nothing comes out
      '{8'h00, 1'b1, 8'h00, {16'h5555, 16'h0055, 16'h5500, 16'hFFFF}, 8'h55,
        1'b1, '{default: '0}},
      '{8'h00, 1'b0, RESET_GYRO_CODE, {16'h5555, 16'h0100, 16'hFF7F, 16'h0080}, 8'hFF,
        1'b0, '{default: '0}},
      '{8'h00, 1'b0, RESET_EULER_CODE, {16'h1234, 16'hEDCB, 16'h0400, 16'h8001}, 8'h7E,
        1'b0, '{default: '0}}
   };

   imu_serial_frame_decoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_value_a    (rsp_value_a),
      .rsp_value_b    (rsp_value_b),
      .rsp_value_c    (rsp_value_c),
      .rsp_value_d    (rsp_value_d),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the frame tracker by one taken byte; return 1 when a reading results
   function automatic bit decode_rx_byte(input logic [7:0] rx, output sensor_reading_type r);
      int w [4];
      logic signed [15:0] word;
      logic [7:0] t;
      r = '{default: '0};
      if (frame_pos == 0) begin
         if (rx == HEADER_BYTE) frame_pos = 1;
         return 1'b0;
      end
      frame_body[frame_pos-1] = rx;
      frame_pos++;
      if (frame_pos < FRAME_BYTES) return 1'b0;
      frame_pos = 0;
      for (int k = 0; k < 4; k++) begin
         word = {frame_body[2+2*k], frame_body[1+2*k]};
         w[k] = word;
      end
      t = frame_body[0];
      // first matching code wins, in accel, gyro, magnet, euler, quat order
      if (t == code_regs.accel) begin
         r.frame_kind = KIND_ACCEL;
         r.value_a = VALUE_W'(w[0] * 49 / 40);
         r.value_b = VALUE_W'(w[1] * 49 / 40);
         r.value_c = VALUE_W'(w[2] * 49 / 40 - 2509);
         r.value_d = VALUE_W'(w[3] * 64 / 25);
      end else if (t == code_regs.gyro) begin
         r.frame_kind = KIND_GYRO;
         r.value_a = VALUE_W'(w[0] * 125 / 8);
         r.value_b = VALUE_W'(w[1] * 125 / 8);
         r.value_c = VALUE_W'(w[2] * 125 / 8);
      end else if (t == code_regs.magnet) begin
         r.frame_kind = KIND_MAGNET;
         r.value_a = VALUE_W'(w[0]);
         r.value_b = VALUE_W'(w[1]);
         r.value_c = VALUE_W'(w[2]);
      end else if (t == code_regs.euler) begin
         r.frame_kind = KIND_EULER;
         r.value_a = VALUE_W'(w[0] * 45 / 32);
         r.value_b = VALUE_W'(w[1] * 45 / 32);
         r.value_c = VALUE_W'(w[2] * 45 / 32);
      end else if (t == code_regs.quat) begin
         r.frame_kind = KIND_QUAT;
         r.value_a = VALUE_W'(w[0]);
         r.value_b = VALUE_W'(w[1]);
         r.value_c = VALUE_W'(w[2]);
         r.value_d = VALUE_W'(w[3]);
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void check_field(input string field, input logic signed [VALUE_W-1:0] want,
                                       input logic signed [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // Present one byte, hold it until taken, then update the expected readings
   task automatic send_byte(input logic [7:0] rx);
      sensor_reading_type r;
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      if (frame_pos != 0 || rx == HEADER_BYTE) bytes_taken++;
      else bytes_dropped++;
      if (decode_rx_byte(rx, r)) pending_readings.push_back(typed_row ? typed_reading : r);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] type_code, input logic [0:3][15:0] words,
                             input logic [7:0] csum);
      send_byte(HEADER_BYTE);
      send_byte(type_code);
      for (int k = 0; k < 4; k++) begin
         send_byte(words[k][7:0]);
         send_byte(words[k][15:8]);
      end
      send_byte(csum);
   endtask

   // Close any open frame, wait out every reading, then let the pipe drain
   task automatic settle();
      while (frame_pos != 0) send_byte(8'h00);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_code(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ACCEL_CODE:  code_regs.accel = data;
         CSR_GYRO_CODE:   code_regs.gyro = data;
         CSR_MAGNET_CODE: code_regs.magnet = data;
         CSR_EULER_CODE:  code_regs.euler = data;
         CSR_QUAT_CODE:   code_regs.quat = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_codes(input logic [7:0] acc, input logic [7:0] gyr, input logic [7:0] mag,
                            input logic [7:0] eul, input logic [7:0] qua);
      write_code(CSR_ACCEL_CODE, acc);
      write_code(CSR_GYRO_CODE, gyr);
      write_code(CSR_MAGNET_CODE, mag);
      write_code(CSR_EULER_CODE, eul);
      write_code(CSR_QUAT_CODE, qua);
      code_settings++;
   endtask

   // Mostly well-formed frames with random content, some idle noise and stray headers
   task automatic run_random(input int frame_byte_goal);
      int goal;
      int pick;
      logic [7:0] t;
      logic [0:3][15:0] words;
      goal = bytes_taken + frame_byte_goal;
      while (bytes_taken < goal) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
         end else begin
            if (pick < 28) begin
               t = 8'($urandom);
            end else begin
               case ($urandom_range(KIND_QUAT))
                  KIND_ACCEL:  t = code_regs.accel;
                  KIND_GYRO:   t = code_regs.gyro;
                  KIND_MAGNET: t = code_regs.magnet;
                  KIND_EULER:  t = code_regs.euler;
                  default:     t = code_regs.quat;
               endcase
            end
            for (int k = 0; k < 4; k++) begin
               case ($urandom_range(11))
                  0: words[k] = 16'h8000;
                  1: words[k] = 16'h7FFF;
                  2: words[k] = 16'hFFFF;
                  3: words[k] = 16'h0000;
                  default: words[k] = 16'($urandom);
               endcase
            end
            send_frame(t, words, 8'($urandom));
         end
      end
      settle();
   endtask

   // Stall the result side at random, except during the calm stretch
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // Compare each reading taken against the oldest expectation
   always @(posedge clock) begin
      sensor_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("reading kind %0d arrived with none expected", rsp_frame_kind);
            fail_count++;
         end else begin
            want = pending_readings.pop_front();
            check_field("frame_kind", VALUE_W'(want.frame_kind), VALUE_W'(rsp_frame_kind));
            check_field("value_a", want.value_a, rsp_value_a);
            check_field("value_b", want.value_b, rsp_value_b);
            check_field("value_c", want.value_c, rsp_value_c);
            check_field("value_d", want.value_d, rsp_value_d);
            readings_checked++;
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      code_regs = '{RESET_ACCEL_CODE, RESET_GYRO_CODE, RESET_MAGNET_CODE, RESET_EULER_CODE,
                    RESET_QUAT_CODE};
      frame_pos = 0;
      typed_row = 1'b0;
      calm = 1'b0;
      bytes_taken = 0;
      bytes_dropped = 0;
      code_settings = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames at reset codes, back to back
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_frames[i].has_lead) send_byte(directed_frames[i].lead);
         typed_row = directed_frames[i].typed;
         typed_reading = directed_frames[i].want;
         send_frame(directed_frames[i].type_code, directed_frames[i].words,
                    directed_frames[i].csum);
         typed_row = 1'b0;
      end
      settle();

      // Writes past the register list must leave the codes alone
      for (int i = int'(CSR_QUAT_CODE) + 1; i < (1 << CSR_INDEX_W); i++)
         write_code(CSR_INDEX_W'(i), 8'($urandom));
      run_random(270);

      // Code extremes, with the header value as a type code
      set_codes(8'h00, 8'hFF, HEADER_BYTE, 8'h01, 8'h80);
      run_random(270);

      // All codes equal, no idling anywhere: accel must win every time
      begin
         logic [7:0] same;
         same = 8'($urandom);
         calm = 1'b1;
         set_codes(same, same, same, same, same);
         run_random(270);
         calm = 1'b0;
      end

      // Random codes with euler shadowing quat
      begin
         logic [7:0] shared;
         shared = 8'($urandom);
         set_codes(8'($urandom), 8'($urandom), 8'($urandom), shared, shared);
         run_random(320);
      end

      // Back to the power-on codes, written explicitly
      set_codes(RESET_ACCEL_CODE, RESET_GYRO_CODE, RESET_MAGNET_CODE, RESET_EULER_CODE,
                RESET_QUAT_CODE);
      run_random(370);

      $display("Decoded %0d readings from %0d frame bytes (%0d idle bytes dropped)",
               readings_checked, bytes_taken, bytes_dropped);
      $display("across %0d type code settings, including code extremes and duplicates.",
               code_settings);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
